// ----- rtl/isp_pkg.sv -----
`default_nettype none

package isp_pkg;

	localparam int HEAD_W  = 31;
	localparam int LEN_W   = 15;
	localparam int SPEED_W = 19;
	localparam int ADDR_W  = 14;
	localparam int SMP_W   = 16;
	localparam int OP_W    = 2;

	localparam int SAMPLE_DEPTH_DEF = 16384;
	localparam int FRAC_BITS_DEF    = 16;

	localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(65536);
	localparam logic [HEAD_W-1:0]  HEAD_MAX    = {HEAD_W{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic {
		CFG_LENGTH = 1'b0,
		CFG_SPEED  = 1'b1
	} cfg_idx_t;

endpackage

`default_nettype wire

// ----- rtl/interpolating_sample_player_unit.sv -----
// A tick beat's result passes stages s1 to s5 and the output register on its way to m_*.
// Throughput: one input beat per cycle; the five-stage read-modify pipeline through the
// dual-read sample memory stalls only while a result waits unaccepted in the output register
// and the next result has reached the last stage.
// Reset clears the read head, stops playback, sets the sample count to 0 and speed to 65536.
// Sample memory contents are undefined after reset until loaded.
`default_nettype none

module interpolating_sample_player_unit #(
	parameter int SAMPLE_DEPTH = isp_pkg::SAMPLE_DEPTH_DEF,
	parameter int FRAC_BITS    = isp_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // address [13:0], sample_value [29:14], zero [31:30]
	input  wire logic [1:0]  s_tuser,   // operation [1:0]

	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // sample_out [15:0]
	output logic             m_tuser,   // past_end [0]

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [18:0] cfg_data
);

	localparam int AW     = $clog2(SAMPLE_DEPTH);
	localparam int HW     = isp_pkg::HEAD_W;
	localparam int IP_W   = HW - FRAC_BITS;
	localparam int LW     = isp_pkg::LEN_W;
	localparam int SW     = isp_pkg::SMP_W;

	logic [LW-1:0]               len_q;
	logic [isp_pkg::SPEED_W-1:0] speed_q;
	logic [HW-1:0]               head_q;
	logic                        playing_q;

	logic                 en;
	logic                 accept;
	isp_pkg::op_t         op;
	logic [isp_pkg::ADDR_W-1:0] in_addr;
	logic signed [SW-1:0] in_val;

	logic [IP_W-1:0]      ip;
	logic                 in_range;
	logic                 frac_hi;
	logic                 edge_lo;
	logic                 edge_hi;
	logic [FRAC_BITS-1:0] t0;
	logic [LW-1:0]        ax;
	logic [LW-1:0]        bx;
	logic [HW:0]          head_sum;

	logic res_s1, res_s2, res_s3, res_s4, res_s5;
	logic past_s1, past_s2, past_s3, past_s4, past_s5;
	logic ld_s1, ld_s2, ld_s3;
	logic [FRAC_BITS-1:0] t_s1, t_s2, t_s3, t_s4;
	logic [AW-1:0]        wa_s1, wa_s2, wa_s3;
	logic signed [SW-1:0] wd_s1, wd_s2, wd_s3;
	logic [LW-1:0]        ax_s1, bx_s1;
	logic [AW-1:0]        ra_s3, rb_s3;
	logic signed [SW-1:0] a_s4, b_s4, y_s5;

	logic                 out_valid_q;
	logic [SW-1:0]        out_data_q;
	logic                 out_past_q;

	assign en       = !(out_valid_q && !m_tready && res_s5);
	assign s_tready = en;
	assign accept   = s_tvalid && s_tready;
	assign op       = isp_pkg::op_t'(s_tuser);
	assign in_addr  = s_tdata[13:0];
	assign in_val   = $signed(s_tdata[29:14]);

	assign ip       = head_q[HW-1:FRAC_BITS];
	assign in_range = 32'(ip) < 32'(len_q);
	assign frac_hi  = head_q[FRAC_BITS-1];
	assign edge_lo  = !frac_hi && (ip == '0);
	assign edge_hi  = frac_hi && ((32'(ip) + 32'd1) >= 32'(len_q));
	assign t0       = (edge_lo || edge_hi) ? '0 : {head_q[FRAC_BITS-2:0], 1'b0};
	assign ax       = (frac_hi || edge_lo) ? LW'(ip) : LW'(ip - IP_W'(1));
	assign bx       = (frac_hi && !edge_hi) ? LW'(ip + IP_W'(1)) : LW'(ip);
	assign head_sum = {1'b0, head_q} + (HW+1)'(speed_q);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			speed_q <= isp_pkg::SPEED_RESET;
		end else if (cfg_valid) begin
			case (isp_pkg::cfg_idx_t'(cfg_index))
				isp_pkg::CFG_LENGTH: len_q   <= cfg_data[LW-1:0];
				isp_pkg::CFG_SPEED:  speed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			playing_q <= 1'b0;
		end else if (accept) begin
			case (op)
				isp_pkg::OP_START: begin
					head_q    <= '0;
					playing_q <= 1'b1;
				end
				isp_pkg::OP_STOP: begin
					head_q    <= '0;
					playing_q <= 1'b0;
				end
				isp_pkg::OP_TICK: begin
					if (playing_q && in_range) begin
						head_q <= head_sum[HW] ? isp_pkg::HEAD_MAX : head_sum[HW-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s1 <= 1'b0;
			res_s2 <= 1'b0;
			res_s3 <= 1'b0;
			res_s4 <= 1'b0;
			res_s5 <= 1'b0;
			ld_s1  <= 1'b0;
			ld_s2  <= 1'b0;
			ld_s3  <= 1'b0;
		end else if (en) begin
			res_s1 <= accept && (op == isp_pkg::OP_TICK) && playing_q;
			res_s2 <= res_s1;
			res_s3 <= res_s2;
			res_s4 <= res_s3;
			res_s5 <= res_s4;
			ld_s1  <= accept && (op == isp_pkg::OP_LOAD)
				&& (32'(in_addr) < 32'(SAMPLE_DEPTH));
			ld_s2  <= ld_s1;
			ld_s3  <= ld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			past_s1 <= !in_range;
			past_s2 <= past_s1;
			past_s3 <= past_s2;
			past_s4 <= past_s3;
			past_s5 <= past_s4;
			t_s1    <= t0;
			t_s2    <= t_s1;
			t_s3    <= t_s2;
			t_s4    <= t_s3;
			ax_s1   <= ax;
			bx_s1   <= bx;
			wa_s1   <= AW'(in_addr);
			wa_s2   <= wa_s1;
			wa_s3   <= wa_s2;
			wd_s1   <= in_val;
			wd_s2   <= wd_s1;
			wd_s3   <= wd_s2;
		end
	end

	isp_wrap #(
		.DEPTH (SAMPLE_DEPTH),
		.AW    (AW)
	) u_wrap_a (
		.clk  (clk),
		.en   (en),
		.x_s1 (ax_s1),
		.r_s3 (ra_s3)
	);

	isp_wrap #(
		.DEPTH (SAMPLE_DEPTH),
		.AW    (AW)
	) u_wrap_b (
		.clk  (clk),
		.en   (en),
		.x_s1 (bx_s1),
		.r_s3 (rb_s3)
	);

	// Loads write at the same stage where ticks read, so accesses stay in beat order.
	isp_store #(
		.DEPTH (SAMPLE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk  (clk),
		.en   (en),
		.we   (ld_s3),
		.wa   (wa_s3),
		.wd   (wd_s3),
		.ra   (ra_s3),
		.rb   (rb_s3),
		.a_s4 (a_s4),
		.b_s4 (b_s4)
	);

	isp_blend #(
		.FRAC_BITS (FRAC_BITS)
	) u_blend (
		.clk  (clk),
		.en   (en),
		.a_s4 (a_s4),
		.b_s4 (b_s4),
		.t_s4 (t_s4),
		.y_s5 (y_s5)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && res_s5) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && res_s5) begin
			out_data_q <= past_s5 ? '0 : y_s5;
			out_past_q <= past_s5;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_past_q;

endmodule

`default_nettype wire

// ----- rtl/isp_wrap.sv -----
`default_nettype none

// Store index modulo the store depth, by a reciprocal multiply over two stages.
module isp_wrap #(
	parameter int DEPTH = isp_pkg::SAMPLE_DEPTH_DEF,
	parameter int AW    = $clog2(isp_pkg::SAMPLE_DEPTH_DEF)
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [isp_pkg::LEN_W-1:0]  x_s1,
	output logic      [AW-1:0]              r_s3
);

	localparam int N  = isp_pkg::LEN_W;
	localparam int SH = N + AW;
	localparam int RW = N + 2;
	localparam int PW = N + RW;
	localparam int QW = N + AW + 1;
	localparam longint unsigned RL = ((64'd1 << SH) + longint'(DEPTH) - 64'd1) / longint'(DEPTH);
	localparam logic [RW-1:0] RECIP = RW'(RL);

	logic [PW-1:0] p_s2;
	logic [N-1:0]  x_s2;
	logic [N-1:0]  qd_s3;
	logic [N-1:0]  x_s3;
	logic [N-1:0]  q;
	logic [QW-1:0] qd_w;
	logic [N-1:0]  r;

	assign q    = N'(p_s2 >> SH);
	assign qd_w = QW'(q) * QW'(DEPTH);
	assign r    = x_s3 - qd_s3;
	assign r_s3 = AW'(r);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2  <= PW'(x_s1) * PW'(RECIP);
			x_s2  <= x_s1;
			qd_s3 <= N'(qd_w);
			x_s3  <= x_s2;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/isp_store.sv -----
`default_nettype none

module isp_store #(
	parameter int DEPTH = isp_pkg::SAMPLE_DEPTH_DEF,
	parameter int AW    = $clog2(isp_pkg::SAMPLE_DEPTH_DEF)
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic                              we,
	input  wire logic [AW-1:0]                     wa,
	input  wire logic signed [isp_pkg::SMP_W-1:0]  wd,
	input  wire logic [AW-1:0]                     ra,
	input  wire logic [AW-1:0]                     rb,
	output logic signed [isp_pkg::SMP_W-1:0]       a_s4,
	output logic signed [isp_pkg::SMP_W-1:0]       b_s4
);

	logic signed [isp_pkg::SMP_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4 <= mem[ra];
			b_s4 <= mem[rb];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/isp_blend.sv -----
`default_nettype none

// y = a + floor((b - a) * t / 2^FRAC_BITS); the arithmetic shift gives the floor.
module isp_blend #(
	parameter int FRAC_BITS = isp_pkg::FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [isp_pkg::SMP_W-1:0]  a_s4,
	input  wire logic signed [isp_pkg::SMP_W-1:0]  b_s4,
	input  wire logic [FRAC_BITS-1:0]              t_s4,
	output logic signed [isp_pkg::SMP_W-1:0]       y_s5
);

	localparam int SW  = isp_pkg::SMP_W;
	localparam int PRW = SW + FRAC_BITS + 2;

	logic signed [SW:0]    diff;
	logic signed [FRAC_BITS:0] t_sx;
	logic signed [PRW-1:0] prod_w;
	logic signed [PRW-1:0] prod_s5;
	logic signed [SW-1:0]  a_s5;
	logic signed [PRW-1:0] sum_w;

	assign diff   = $signed({b_s4[SW-1], b_s4}) - $signed({a_s4[SW-1], a_s4});
	assign t_sx   = $signed({1'b0, t_s4});
	assign prod_w = PRW'(diff) * PRW'(t_sx);
	assign sum_w  = PRW'(a_s5) + (prod_s5 >>> FRAC_BITS);
	assign y_s5   = SW'(sum_w);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= prod_w;
			a_s5    <= a_s4;
		end
	end

endmodule

`default_nettype wire
